### rtl/ibn_pkg.sv
package ibn_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 63;

    localparam int BASE_WIDTH  = 5;
    localparam int REM_WIDTH   = 4;
    localparam int DIGIT_WIDTH = 7;

    localparam logic [BASE_WIDTH-1:0]  BASE_RESET     = 5'd10;
    localparam logic [BASE_WIDTH-1:0]  BASE_MIN       = 5'd2;
    localparam logic [BASE_WIDTH-1:0]  BASE_MAX       = 5'd16;
    localparam logic [DIGIT_WIDTH-1:0] ASCII_ZERO     = 7'd48;
    localparam logic [DIGIT_WIDTH-1:0] ASCII_LETTER_A = 7'd65;
    localparam logic [REM_WIDTH-1:0]   DECIMAL_LIMIT  = 4'd10;

    typedef struct packed {
        logic load;     // take a new value, clear remainder
        logic restart;  // clear remainder for the next digit
        logic step;     // one restoring division step
        logic capture;  // move finished digit into output register
    } ibn_cmd_t;

    typedef struct packed {
        logic quo_zero; // quotient is zero: current digit is the last
    } ibn_status_t;

    // out-of-range radix is clamped into 2..16
    function automatic logic [BASE_WIDTH-1:0] effective_base(input logic [BASE_WIDTH-1:0] b);
        logic [BASE_WIDTH-1:0] r;
        if (b < BASE_MIN)
        begin
            r = BASE_MIN;
        end
        else if (b > BASE_MAX)
        begin
            r = BASE_MAX;
        end
        else
        begin
            r = b;
        end
        return r;
    endfunction

    function automatic logic [DIGIT_WIDTH-1:0] digit_to_ascii(input logic [REM_WIDTH-1:0] r);
        logic [DIGIT_WIDTH-1:0] c;
        if (r < DECIMAL_LIMIT)
        begin
            c = ASCII_ZERO + DIGIT_WIDTH'(r);
        end
        else
        begin
            c = ASCII_LETTER_A + DIGIT_WIDTH'(r - DECIMAL_LIMIT);
        end
        return c;
    endfunction

endpackage

### rtl/integer_to_base_n_digits_top.sv
// Radix conversion: each accepted value is turned into ASCII digits in the base held in the
// base register (2..16; 0 and 1 act as 2, 17..31 as 16), least significant digit first, one
// result per digit, with last set on the final, most significant digit. Zero gives the single
// digit '0'. Digits come from a bit-serial restoring divider that retires one quotient bit a
// cycle and takes VALUE_WIDTH division steps per digit; a stall on the output side holds each
// finished digit until the output register is free. One request is in work at a time; the
// next is accepted as soon as the final digit sits in the output register.
// Write base only while no request is in progress.
module integer_to_base_n_digits_top #(
    parameter int VALUE_WIDTH = ibn_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ibn_pkg::BASE_WIDTH-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [VALUE_WIDTH-1:0]          value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ibn_pkg::DIGIT_WIDTH-1:0] digit_char,
    output logic                            last
);

    ibn_pkg::ibn_cmd_t    cmd;
    ibn_pkg::ibn_status_t status;

    ibn_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ibn_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule

### rtl/ibn_dpath.sv
module ibn_dpath #(
    parameter int VALUE_WIDTH = ibn_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ibn_pkg::BASE_WIDTH-1:0]      cfg_data,
    input  logic [VALUE_WIDTH-1:0]              value,
    input  ibn_pkg::ibn_cmd_t                   cmd,
    output ibn_pkg::ibn_status_t                status,
    output logic [ibn_pkg::DIGIT_WIDTH-1:0]     digit_char,
    output logic                                last
);

    logic [ibn_pkg::BASE_WIDTH-1:0]  base_reg;
    logic [ibn_pkg::BASE_WIDTH-1:0]  base_eff;
    logic [VALUE_WIDTH-1:0]          quo_reg;
    logic [VALUE_WIDTH-1:0]          quo_next;
    logic [ibn_pkg::REM_WIDTH-1:0]   rem_reg;
    logic [ibn_pkg::REM_WIDTH-1:0]   rem_next;
    logic [ibn_pkg::BASE_WIDTH-1:0]  shifted;
    logic [ibn_pkg::BASE_WIDTH-1:0]  diff;
    logic                            ge;
    logic [ibn_pkg::DIGIT_WIDTH-1:0] digit_reg;
    logic                            last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= ibn_pkg::BASE_RESET;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_data;
        end
    end

    assign base_eff = ibn_pkg::effective_base(base_reg);

    // restoring step: remainder stays below base, so 4 bits hold it between steps
    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign ge      = (shifted >= base_eff);
    assign diff    = shifted - base_eff;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (cmd.load)
        begin
            quo_next = value;
            rem_next = '0;
        end
        else if (cmd.step)
        begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], ge};
            rem_next = ge ? diff[ibn_pkg::REM_WIDTH-1:0] : shifted[ibn_pkg::REM_WIDTH-1:0];
        end
        else if (cmd.restart)
        begin
            rem_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.capture)
        begin
            digit_reg <= ibn_pkg::digit_to_ascii(rem_reg);
            last_reg  <= (quo_reg == '0);
        end
    end

    assign status.quo_zero = (quo_reg == '0);
    assign digit_char      = digit_reg;
    assign last            = last_reg;

endmodule

### rtl/ibn_ctrl.sv
module ibn_ctrl #(
    parameter int VALUE_WIDTH = ibn_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  ibn_pkg::ibn_status_t status,
    output ibn_pkg::ibn_cmd_t    cmd
);

    localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

    typedef enum logic [1:0] {
        IDLE,
        DIV,
        DONE
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [CNT_WIDTH-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;
    logic                 in_accept;
    logic                 cnt_end;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != IDLE);
    assign in_accept = in_valid && (state_reg == IDLE);
    assign cnt_end   = (cnt_reg == CNT_WIDTH'(VALUE_WIDTH - 1));

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = DIV;
                end
            end
            DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end)
                begin
                    state_next = DONE;
                end
            end
            DONE:
            begin
                // hand the digit over once the output register is free
                if (out_free)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.quo_zero)
                    begin
                        state_next = IDLE;
                    end
                    else
                    begin
                        cmd.restart = 1'b1;
                        cnt_next    = '0;
                        state_next  = DIV;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> out_free)
        else $error("digit captured over a waiting result");

    a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == DIV) && (cnt_reg == '0))
        else $error("accepted request did not start division");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && status.quo_zero) |=> (state_reg == IDLE) && out_valid_reg)
        else $error("final digit did not end the request");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DIV && cnt_end) |=> (state_reg == DONE))
        else $error("division step count wrong");

endmodule

### bench/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW          = ibn_pkg::VALUE_WIDTH_DEFAULT;
    localparam int LONG_HOLD   = 1500;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 2 * (VW + 1);

    typedef struct packed {
        logic [ibn_pkg::DIGIT_WIDTH-1:0] ch;
        logic                            fin;
    } digit_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [ibn_pkg::BASE_WIDTH-1:0]  cfg_data  = ibn_pkg::BASE_RESET;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [VW-1:0]                   value     = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [ibn_pkg::DIGIT_WIDTH-1:0] digit_char;
    logic                            last;

    logic [VW-1:0]                  values_pending[$];
    digit_t                         digits_due[$];
    logic [ibn_pkg::BASE_WIDTH-1:0] radix = ibn_pkg::BASE_RESET;
    int                             send_idle_pct = 0;
    int                             recv_idle_pct = 0;
    int                             hold_token = 0;
    int                             hold_seen  = 0;
    int                             hold_left  = 0;
    int                             fail_count = 0;
    int                             quiet_cycles = 0;

    integer_to_base_n_digits_top #(
        .VALUE_WIDTH(VW)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .digit_char(digit_char),
        .last      (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // repeated division, least significant digit first
    function automatic void predict_digits(input logic [VW-1:0] v_in,
                                           input logic [ibn_pkg::BASE_WIDTH-1:0] b);
        logic [63:0] v;
        logic [63:0] eb;
        logic [63:0] rem;
        digit_t      d;
        v  = 64'(v_in);
        eb = (b < ibn_pkg::BASE_MIN) ? 64'(ibn_pkg::BASE_MIN) :
             (b > ibn_pkg::BASE_MAX) ? 64'(ibn_pkg::BASE_MAX) : 64'(b);
        do
        begin
            rem = v % eb;
            v   = v / eb;
            if (rem < 64'(ibn_pkg::DECIMAL_LIMIT))
                d.ch = ibn_pkg::ASCII_ZERO + ibn_pkg::DIGIT_WIDTH'(rem);
            else
                d.ch = ibn_pkg::ASCII_LETTER_A
                       + ibn_pkg::DIGIT_WIDTH'(rem - 64'(ibn_pkg::DECIMAL_LIMIT));
            d.fin = (v == 64'd0);
            digits_due.insert(digits_due.size(), d);
        end
        while (v != 64'd0);
    endfunction

    function automatic void add_request(input logic [VW-1:0] v);
        values_pending.insert(values_pending.size(), v);
    endfunction

    // mostly short values so that base 2 runs stay affordable
    function automatic logic [VW-1:0] random_value();
        logic [63:0] r;
        int          pick;
        r    = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        if (pick < 8)
            return '1;
        if (pick < 60)
            return VW'(r >> $urandom_range(62, 48));
        if (pick < 85)
            return VW'(r >> $urandom_range(47, 24));
        return VW'(r);
    endfunction

    function automatic logic [ibn_pkg::BASE_WIDTH-1:0] random_base();
        if ($urandom_range(3) != 0)
            return ibn_pkg::BASE_WIDTH'($urandom_range(31));
        case ($urandom_range(5))
            0: return 5'd0;
            1: return 5'd1;
            2: return ibn_pkg::BASE_MIN;
            3: return ibn_pkg::BASE_MAX;
            4: return 5'd17;
            default: return 5'd31;
        endcase
    endfunction

    // driver: holds a request until taken, then picks the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_digits(value, radix);
            if (!in_valid || !in_stall)
            begin
                if (values_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    value    <= values_pending.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks digits and drives the output stall
    always @(posedge clk or negedge rst_n)
    begin
        digit_t exp_d;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (digits_due.size() == 0)
                begin
                    $display("%0t: unexpected digit, expected none, got char %0d last %0b",
                             $time, digit_char, last);
                    fail_count++;
                end
                else
                begin
                    exp_d = digits_due.pop_front();
                    if (digit_char !== exp_d.ch)
                    begin
                        $display("%0t: digit_char mismatch, expected %0d, got %0d",
                                 $time, exp_d.ch, digit_char);
                        fail_count++;
                    end
                    if (last !== exp_d.fin)
                    begin
                        $display("%0t: last mismatch, expected %0b, got %0b",
                                 $time, exp_d.fin, last);
                        fail_count++;
                    end
                end
            end
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request or digit moved for %0d cycles", $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_base(input logic [ibn_pkg::BASE_WIDTH-1:0] b);
        @(posedge clk);
        cfg_data <= b;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        radix = b;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (values_pending.size() != 0 || in_valid || digits_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 87;

        // reset radix (decimal): zero, single digits, carries, extremes
        add_request('0);
        add_request(VW'(1));
        add_request(VW'(9));
        add_request(VW'(10));
        add_request(VW'(64'd1000000000000000000));
        add_request('1);
        wait_idle();

        write_base(ibn_pkg::BASE_MAX);
        add_request('0);
        add_request(VW'(15));
        add_request(VW'(64'h7EDC_BA98_7654_3210));
        add_request('1);
        wait_idle();

        write_base(ibn_pkg::BASE_MIN);
        add_request('0);
        add_request(VW'(1));
        add_request(VW'(64'h4000_0000_0000_0000));
        add_request('1);
        wait_idle();

        // radix below two acts as binary
        write_base(5'd0);
        add_request(VW'(6));
        add_request('0);
        wait_idle();
        write_base(5'd1);
        add_request(VW'(5));
        wait_idle();

        // radix above sixteen acts as hex
        write_base(5'd31);
        add_request('1);
        add_request(VW'(255));
        wait_idle();
        write_base(5'd17);
        add_request(VW'(300));
        wait_idle();

        write_base(5'd7);
        add_request(VW'(48));
        add_request(VW'(64'h2AAA_AAAA_AAAA_AAAA));
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_base(random_base());
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct = 35;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // long output hold while requests keep coming
            if (ph == 2 || ph == 4)
                hold_token++;
            repeat (20) add_request(random_value());
            wait_idle();
        end

        repeat (TAIL) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
